// ----- sv/chat_format_code_stripper_assert.svh -----
// Assertion macros for the chat format code stripper checker.
`ifndef CHAT_FORMAT_CODE_STRIPPER_ASSERT_SVH
`define CHAT_FORMAT_CODE_STRIPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ccs_pkg.sv -----
`default_nettype none

package ccs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_WR   = 4'b0100,
		ST_TAIL = 4'b1000
	} state_t;

	// tuser bit positions on the output stream
	localparam int unsigned USER_VALID_BIT    = 0;
	localparam int unsigned USER_RUN_LAST_BIT = 1;

	localparam logic [7:0] CH_COLOR   = 8'h03;
	localparam logic [7:0] CH_RGB     = 8'h04;
	localparam logic [7:0] CH_REVERSE = 8'h16;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_BOLD    = 8'h02;
	localparam logic [7:0] CH_PLAIN   = 8'h0f;
	localparam logic [7:0] CH_MONO    = 8'h11;
	localparam logic [7:0] CH_ITALIC  = 8'h1d;
	localparam logic [7:0] CH_STRIKE  = 8'h1e;
	localparam logic [7:0] CH_ULINE   = 8'h1f;
	localparam logic [7:0] ZWSP_B0    = 8'he2;
	localparam logic [7:0] ZWSP_B1    = 8'h80;
	localparam logic [7:0] ZWSP_B2    = 8'h8b;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic is_fmt(input logic [7:0] c);
		return (c == CH_BOLD) || (c == CH_PLAIN) || (c == CH_MONO) ||
			(c == CH_ITALIC) || (c == CH_STRIKE) || (c == CH_ULINE);
	endfunction

endpackage

`default_nettype wire

// ----- sv/chat_format_code_stripper.sv -----
// The first word is registered in the cycle after accept, unless a failed RGB run replays
// first. Throughput: one byte per cycle while the output is not stalled and each byte yields
// at most one word; every extra kept word (partial zero-width-space flush) adds a tail step,
// and a replayed byte takes an ST_RD read, then an ST_WR load, from the buffer memory.
// Reset: arst_n clears all control state and sets strip_mode to 1; the buffer is not cleared.
`default_nettype none

module chat_format_code_stripper #(
	parameter int unsigned REPLAY_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,      // strip_mode
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // in_byte
	input  wire logic       s_axis_tlast,   // in_message_last
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // out_byte
	output logic [1:0]      m_axis_tuser,   // [0] out_valid, [1] run_last
	output logic            m_axis_tlast    // out_message_last
);

	localparam int unsigned AW = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
	localparam int unsigned CW = $clog2(REPLAY_DEPTH + 1);

	ccs_pkg::state_t state_q;

	logic          strip_mode_q;
	logic          color_q, rgb_q;
	logic [2:0]    dc_q;
	logic [CW-1:0] held_q;
	logic [1:0]    utf_q;

	logic [7:0]    mem [REPLAY_DEPTH];
	logic [7:0]    mem_rd_q;
	logic [CW-1:0] rd_ptr_q, rep_cnt_q;
	logic [2:0][7:0] tail_q;
	logic [1:0]    tcnt_q, tidx_q;
	logic          last_q;

	logic          out_free, accept;

	// next-state view of one accepted byte
	logic          n_color, n_rgb;
	logic [2:0]    n_dc;
	logic [CW-1:0] n_held;
	logic [1:0]    n_utf;
	logic          do_write, fresh, cont, bare;
	logic [CW-1:0] rep_n;
	logic [4:0]    sel;
	logic [4:0][7:0] cand;
	logic [2:0][7:0] tl;
	logic [1:0]    tcnt;
	logic          hit_color, hit_rgb, is_comma;
	logic [7:0]    b;

	logic          rd_done;

	// output register load
	logic          out_load;
	logic [7:0]    o_data;
	logic [1:0]    o_user;
	logic          o_last;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ccs_pkg::ST_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign is_comma      = (b == ccs_pkg::CH_COMMA);
	assign rd_done       = ((rd_ptr_q + CW'(1)) == rep_cnt_q);

	always_comb begin
		n_color  = color_q;
		n_rgb    = rgb_q;
		n_dc     = dc_q;
		n_held   = held_q;
		n_utf    = utf_q;
		do_write = 1'b0;
		fresh    = 1'b0;
		cont     = 1'b1;
		rep_n    = '0;
		sel      = '0;
		cand[0]  = ccs_pkg::ZWSP_B0;
		cand[1]  = ccs_pkg::ZWSP_B1;
		cand[2]  = b;
		cand[3]  = ccs_pkg::ZWSP_B0;
		cand[4]  = ccs_pkg::ZWSP_B1;
		tl       = '0;
		tcnt     = '0;

		hit_color = color_q && ((ccs_pkg::is_dec(b) && dc_q < 3'd2) ||
			(is_comma && dc_q < 3'd3));
		hit_rgb   = rgb_q && ((ccs_pkg::is_hex(b) && dc_q < 3'd6) ||
			(is_comma && dc_q < 3'd7));

		if (hit_color) begin
			n_dc = is_comma ? 3'd0 : dc_q + 3'd1;
		end else if (hit_rgb) begin
			if (held_q >= CW'(REPLAY_DEPTH)) begin
				// buffer full: give the run back and keep this byte
				rep_n  = held_q;
				n_rgb  = 1'b0;
				n_dc   = '0;
				n_held = '0;
				fresh  = 1'b1;
			end else begin
				do_write = 1'b1;
				n_held   = held_q + CW'(1);
				n_dc     = is_comma ? 3'd0 : dc_q + 3'd1;
			end
		end else begin
			n_color = 1'b0;
			if (rgb_q) begin
				if (dc_q != 3'd6)
					rep_n = held_q;
				n_rgb  = 1'b0;
				n_held = '0;
				n_dc   = '0;
			end
			fresh = 1'b1;
		end

		if (fresh) begin
			if (utf_q == 2'd1) begin
				if (b == ccs_pkg::ZWSP_B1) begin
					n_utf = 2'd2;
					cont  = 1'b0;
				end else begin
					sel[0] = 1'b1;
					n_utf  = 2'd0;
				end
			end else if (utf_q == 2'd2) begin
				n_utf = 2'd0;
				if (b == ccs_pkg::ZWSP_B2) begin
					cont = 1'b0;
				end else begin
					sel[0] = 1'b1;
					sel[1] = 1'b1;
				end
			end
			if (cont) begin
				if (b == ccs_pkg::CH_COLOR) begin
					n_color = 1'b1;
					n_dc    = '0;
				end else if (b == ccs_pkg::CH_RGB) begin
					n_rgb  = 1'b1;
					n_dc   = '0;
					n_held = '0;
				end else if (b == ccs_pkg::CH_REVERSE) begin
					n_dc = n_dc;
				end else if (strip_mode_q && ccs_pkg::is_fmt(b)) begin
					n_dc = n_dc;
				end else if (strip_mode_q && b == ccs_pkg::ZWSP_B0) begin
					n_utf = 2'd1;
				end else begin
					sel[2] = 1'b1;
				end
			end
		end

		if (s_axis_tlast) begin
			// message end: flush a partial zero-width space, drop everything else
			sel[3]  = (n_utf != 2'd0);
			sel[4]  = (n_utf == 2'd2);
			n_utf   = '0;
			n_color = 1'b0;
			n_rgb   = 1'b0;
			n_dc    = '0;
			n_held  = '0;
		end

		for (int i = 0; i < 5; i++) begin
			if (sel[i] && tcnt != 2'd3) begin
				tl[tcnt] = cand[i];
				tcnt     = tcnt + 2'd1;
			end
		end

		bare = s_axis_tlast && (rep_n == '0) && (tcnt == 2'd0);
	end

	always_comb begin
		out_load = 1'b0;
		o_data   = tl[0];
		o_user   = '0;
		o_last   = 1'b0;
		unique case (state_q)
			ccs_pkg::ST_IDLE: begin
				out_load = accept && (rep_n == '0) && (tcnt != 2'd0 || bare);
				o_data   = tl[0];
				o_user[ccs_pkg::USER_VALID_BIT]    = !bare;
				o_user[ccs_pkg::USER_RUN_LAST_BIT] = (tcnt <= 2'd1);
				o_last   = s_axis_tlast && (tcnt <= 2'd1);
			end
			ccs_pkg::ST_RD: begin
				out_load = 1'b0;
			end
			ccs_pkg::ST_WR: begin
				out_load = out_free;
				o_data   = mem_rd_q;
				o_user[ccs_pkg::USER_VALID_BIT]    = 1'b1;
				o_user[ccs_pkg::USER_RUN_LAST_BIT] = rd_done && (tcnt_q == 2'd0);
				o_last   = rd_done && (tcnt_q == 2'd0) && last_q;
			end
			ccs_pkg::ST_TAIL: begin
				out_load = out_free;
				o_data   = tail_q[tidx_q];
				o_user[ccs_pkg::USER_VALID_BIT]    = 1'b1;
				o_user[ccs_pkg::USER_RUN_LAST_BIT] = (tidx_q == tcnt_q - 2'd1);
				o_last   = (tidx_q == tcnt_q - 2'd1) && last_q;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && do_write)
			mem[held_q[AW-1:0]] <= b;
		if (state_q == ccs_pkg::ST_RD)
			mem_rd_q <= mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= o_data;
			m_axis_tuser <= o_user;
			m_axis_tlast <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_mode_q  <= 1'b1;
			state_q       <= ccs_pkg::ST_IDLE;
			color_q       <= 1'b0;
			rgb_q         <= 1'b0;
			dc_q          <= '0;
			held_q        <= '0;
			utf_q         <= '0;
			rd_ptr_q      <= '0;
			rep_cnt_q     <= '0;
			tcnt_q        <= '0;
			tidx_q        <= '0;
			last_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we)
				strip_mode_q <= cfg_wdata;
			if (out_load)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;

			unique case (state_q)
				ccs_pkg::ST_IDLE: begin
					if (accept) begin
						color_q   <= n_color;
						rgb_q     <= n_rgb;
						dc_q      <= n_dc;
						held_q    <= n_held;
						utf_q     <= n_utf;
						tail_q    <= tl;
						tcnt_q    <= tcnt;
						last_q    <= s_axis_tlast;
						rep_cnt_q <= rep_n;
						rd_ptr_q  <= '0;
						if (rep_n != '0) begin
							state_q <= ccs_pkg::ST_RD;
						end else if (tcnt > 2'd1) begin
							tidx_q  <= 2'd1;
							state_q <= ccs_pkg::ST_TAIL;
						end
					end
				end
				ccs_pkg::ST_RD: begin
					state_q <= ccs_pkg::ST_WR;
				end
				ccs_pkg::ST_WR: begin
					if (out_free) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
						if (!rd_done) begin
							state_q <= ccs_pkg::ST_RD;
						end else if (tcnt_q != 2'd0) begin
							tidx_q  <= '0;
							state_q <= ccs_pkg::ST_TAIL;
						end else begin
							state_q <= ccs_pkg::ST_IDLE;
						end
					end
				end
				ccs_pkg::ST_TAIL: begin
					if (out_free) begin
						tidx_q <= tidx_q + 2'd1;
						if (tidx_q == tcnt_q - 2'd1)
							state_q <= ccs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ccs_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/ccs_checker.sv -----
`default_nettype none
`include "chat_format_code_stripper_assert.svh"

module ccs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [1:0] m_axis_tuser,
	input wire logic       m_axis_tlast
);

	logic out_vld, out_run_last;

	assign out_vld      = m_axis_tuser[ccs_pkg::USER_VALID_BIT];
	assign out_run_last = m_axis_tuser[ccs_pkg::USER_RUN_LAST_BIT];

	// a stalled word holds
	`CCS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

	// message end closes the run of its byte
	`CCS_ASSERT_NOW(a_last_run, clk, arst_n, m_axis_tvalid && m_axis_tlast, out_run_last, "message end without run end")

	// a bare marker only ends a message and carries a zero byte
	`CCS_ASSERT_NOW(a_bare, clk, arst_n, m_axis_tvalid && !out_vld, m_axis_tdata == 8'h00 && out_run_last && m_axis_tlast, "malformed end marker")

	// no new byte is taken while a word is stalled at the output
	`CCS_ASSERT_NOW(a_no_take, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")

endmodule

bind chat_format_code_stripper ccs_checker u_ccs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
